// ----- src/tsof_pkg.sv -----
// Shared widths, constants and codes of the Tustin second-order filter.
package tsof_pkg;

  localparam int DATA_W    = 32;
  localparam int T_W       = 20;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 4;
  localparam int NTERM     = 6;
  localparam int M_W       = 42;
  localparam int PT_W      = 41;
  localparam int TT_W      = 40;
  localparam int VEC_W     = 35;
  localparam int OPB_W     = 26;
  localparam int PROD_W    = VEC_W + OPB_W;
  localparam int COEF_W    = 75;
  localparam int DEN_W     = 77;
  localparam int ACC_W     = 116;
  localparam int Q_W       = 34;
  localparam int SH_W      = 6;
  localparam int CNT_W     = 6;
  localparam int DIV_LAST  = 34;

  // Chunk sizes of the shared multiplier's second operand.
  localparam int CHUNK_M   = 21;
  localparam int CHUNK_C   = 25;

  // 2 / 1 us and its square.
  localparam logic [20:0]    TWO_PER_US = 21'd2000000;
  localparam logic [M_W-1:0] PP         = 42'd4000000000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_S2   = 4'd0,
    REG_NUM_S1   = 4'd1,
    REG_NUM_S0   = 4'd2,
    REG_DEN_S2   = 4'd3,
    REG_DEN_S1   = 4'd4,
    REG_DEN_S0   = 4'd5,
    REG_CLAMP_LI = 4'd6,
    REG_CLAMP_EN = 4'd7
  } reg_idx_t;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PREP  = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_DRAIN = 9'b000001000,
    ST_DIVP1 = 9'b000010000,
    ST_DIVP2 = 9'b000100000,
    ST_DIVP3 = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

endpackage

// ----- src/tsof_if.sv -----
// Valid/ready channel interfaces of the Tustin second-order filter.
interface tsof_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsof_pkg::DATA_W-1:0]  sample;
  logic        [tsof_pkg::T_W-1:0]     step_time_us;
  modport source (output valid, sample, step_time_us, input ready);
  modport sink   (input valid, sample, step_time_us, output ready);
endinterface

interface tsof_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tsof_pkg::DATA_W-1:0]  filtered;
  logic                                invalid;
  modport source (output valid, filtered, invalid, input ready);
  modport sink   (input valid, filtered, invalid, output ready);
endinterface

interface tsof_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tsof_pkg::CFG_IDX_W-1:0]      index;
  logic [tsof_pkg::DATA_W-1:0]         data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/tustin_second_order_filter_top.sv -----
// Top level of the Tustin second-order filter: sequencer, shared multiplier, divider.
//
//  channel | dir | payload                         | word accepted when
//  in_s    | in  | sample[31:0] s, step_time_us[19:0] | valid && ready
//  out_m   | out | filtered[31:0] s, invalid       | valid && ready
//  cfg_s   | in  | index[3:0], data[31:0]          | valid && ready (ready tied high)
//
// Steps: an accepted word reaches the result register through prep, the passes of the shared
// 35x26 multiplier (6 coefficient products x 2 chunks, then 6 history terms x 3 chunks),
// drain, divider setup (DIVP1, DIVP2, DIVP3), 35 restoring divide steps and finish. The
// next word is taken only once the sequencer is back in idle. A zero denominator skips
// DIVP3 and the divide loop. The divide loop yields one quotient bit per cycle.
// Reset (rst_n low, synchronous) restores the register defaults and clears the history.
// in_s.ready is high only while idle; the result register holds a finished word while
// out_m stalls, and the next word may enter meanwhile; finish waits for a free register.
module tustin_second_order_filter_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  tsof_in_if.sink           in_s,
  tsof_out_if.source        out_m,
  tsof_cfg_if.sink          cfg_s
);

  localparam int DW = tsof_pkg::DATA_W;
  localparam int VW = tsof_pkg::VEC_W;
  localparam int AW = tsof_pkg::ACC_W;
  localparam int CW = tsof_pkg::COEF_W;
  localparam int NW = tsof_pkg::DEN_W;
  localparam int QW = tsof_pkg::Q_W;
  localparam logic signed [DW-1:0] ONE_Q = DW'(64'd1 << FRAC_BITS);

  tsof_pkg::state_t state_r, state_nxt;

  // Configuration registers; coefficients in order num_s2, num_s1, num_s0, den_s2..den_s0.
  logic signed [DW-1:0]                 cfgc_r [tsof_pkg::NTERM];
  logic [tsof_pkg::LIM_W-1:0]           clamp_lim_r;
  logic                                 clamp_en_r;

  // Filter history.
  logic signed [DW-1:0]                 pi1_r, pi2_r, po1_r, po2_r;

  // Current word and per-word operands.
  logic signed [DW-1:0]                 x_r;
  logic [tsof_pkg::T_W-1:0]             t_r;
  logic [tsof_pkg::PT_W-1:0]            pt_r;
  logic [tsof_pkg::TT_W-1:0]            tt_r;
  logic signed [VW-1:0]                 vec_r [tsof_pkg::NTERM];

  // Multiplier sequencing.
  logic                                 ph_r;
  logic [2:0]                           j_r;
  logic [1:0]                           c_r;
  logic                                 last_c;
  logic signed [VW-1:0]                 op_a;
  logic signed [tsof_pkg::OPB_W-1:0]    op_b;
  logic [tsof_pkg::SH_W-1:0]            sh;
  logic [tsof_pkg::M_W-1:0]             m_sel;
  logic signed [CW-1:0]                 coef_sel;
  logic signed [tsof_pkg::PROD_W-1:0]   prod_r;
  logic                                 pv_r, pph_r;
  logic [2:0]                           pj_r;
  logic [tsof_pkg::SH_W-1:0]            psh_r;
  logic signed [AW-1:0]                 ext;

  logic signed [CW-1:0]                 coef_r [tsof_pkg::NTERM];
  logic signed [AW-1:0]                 acc_r;

  // Divider.
  logic signed [NW-1:0]                 den_r;
  logic [AW-1:0]                        nabs_r;
  logic                                 nneg_r;
  logic [NW-1:0]                        dabs_r;
  logic                                 neg_r, inv_r, ovf_r;
  logic [AW-1:0]                        rem_r, ds_r;
  logic                                 ge;
  logic [QW-1:0]                        q_r;
  logic [tsof_pkg::CNT_W-1:0]           cnt_r;

  // Result.
  logic signed [DW-1:0]                 y, lim;
  logic                                 out_valid_r, inv_out_r;
  logic signed [DW-1:0]                 filt_r;
  logic                                 fin_go;

  assign in_s.ready     = (state_r == tsof_pkg::ST_IDLE);
  assign cfg_s.ready    = 1'b1;
  assign out_m.valid    = out_valid_r;
  assign out_m.filtered = filt_r;
  assign out_m.invalid  = inv_out_r;

  assign fin_go = (state_r == tsof_pkg::ST_FIN) && (!out_valid_r || out_m.ready);
  assign last_c = ph_r ? (c_r == 2'd2) : (c_r == 2'd1);
  assign ge     = (rem_r >= ds_r);

  // Operand select of the shared multiplier. First pass builds coef*{pp,pt,tt};
  // second pass multiplies those products by the combined history terms.
  always_comb begin
    case (j_r)
      3'd0, 3'd3: m_sel = tsof_pkg::PP;
      3'd1, 3'd4: m_sel = tsof_pkg::M_W'(pt_r);
      default:    m_sel = tsof_pkg::M_W'(tt_r);
    endcase
    coef_sel = coef_r[j_r];
    if (!ph_r) begin
      op_a = VW'(cfgc_r[j_r]);
      if (c_r[0]) begin
        op_b = {5'b0, m_sel[41:21]};
        sh   = tsof_pkg::SH_W'(tsof_pkg::CHUNK_M);
      end else begin
        op_b = {5'b0, m_sel[20:0]};
        sh   = '0;
      end
    end else begin
      op_a = vec_r[j_r];
      case (c_r)
        2'd0: begin
          op_b = {1'b0, coef_sel[24:0]};
          sh   = '0;
        end
        2'd1: begin
          op_b = {1'b0, coef_sel[49:25]};
          sh   = tsof_pkg::SH_W'(tsof_pkg::CHUNK_C);
        end
        default: begin
          op_b = {coef_sel[74], coef_sel[74:50]};
          sh   = tsof_pkg::SH_W'(2 * tsof_pkg::CHUNK_C);
        end
      endcase
    end
  end

  assign ext = AW'(prod_r) <<< psh_r;

  // Round-to-nearest quotient, saturation and clamp.
  always_comb begin
    lim = {1'b0, clamp_lim_r};
    if (inv_r) begin
      y = '0;
    end else if (!neg_r) begin
      y = (ovf_r || q_r > QW'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : q_r[31:0];
    end else begin
      y = (ovf_r || q_r > QW'(32'h80000000)) ? 32'sh80000000 : -q_r[31:0];
    end
    if (clamp_en_r) begin
      if (y > lim) begin
        y = lim;
      end else if (y < -lim) begin
        y = -lim;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsof_pkg::ST_IDLE:  if (in_s.valid) state_nxt = tsof_pkg::ST_PREP;
      tsof_pkg::ST_PREP:  state_nxt = tsof_pkg::ST_MUL;
      tsof_pkg::ST_MUL:   if (ph_r && last_c && j_r == 3'd5) state_nxt = tsof_pkg::ST_DRAIN;
      tsof_pkg::ST_DRAIN: state_nxt = tsof_pkg::ST_DIVP1;
      tsof_pkg::ST_DIVP1: state_nxt = tsof_pkg::ST_DIVP2;
      tsof_pkg::ST_DIVP2: state_nxt = (den_r == '0) ? tsof_pkg::ST_FIN : tsof_pkg::ST_DIVP3;
      tsof_pkg::ST_DIVP3: state_nxt = tsof_pkg::ST_DIV;
      tsof_pkg::ST_DIV:   if (cnt_r == tsof_pkg::CNT_W'(tsof_pkg::DIV_LAST)) begin
                            state_nxt = tsof_pkg::ST_FIN;
                          end
      tsof_pkg::ST_FIN:   if (fin_go) state_nxt = tsof_pkg::ST_IDLE;
      default:            state_nxt = tsof_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsof_pkg::ST_IDLE;
      cfgc_r[0]   <= '0;
      cfgc_r[1]   <= '0;
      cfgc_r[2]   <= ONE_Q;
      cfgc_r[3]   <= '0;
      cfgc_r[4]   <= '0;
      cfgc_r[5]   <= ONE_Q;
      clamp_lim_r <= '1;
      clamp_en_r  <= 1'b0;
      pi1_r       <= '0;
      pi2_r       <= '0;
      po1_r       <= '0;
      po2_r       <= '0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_s.valid) begin
        case (tsof_pkg::reg_idx_t'(cfg_s.index))
          tsof_pkg::REG_NUM_S2:   cfgc_r[0]   <= cfg_s.data;
          tsof_pkg::REG_NUM_S1:   cfgc_r[1]   <= cfg_s.data;
          tsof_pkg::REG_NUM_S0:   cfgc_r[2]   <= cfg_s.data;
          tsof_pkg::REG_DEN_S2:   cfgc_r[3]   <= cfg_s.data;
          tsof_pkg::REG_DEN_S1:   cfgc_r[4]   <= cfg_s.data;
          tsof_pkg::REG_DEN_S0:   cfgc_r[5]   <= cfg_s.data;
          tsof_pkg::REG_CLAMP_LI: clamp_lim_r <= cfg_s.data[30:0];
          tsof_pkg::REG_CLAMP_EN: clamp_en_r  <= cfg_s.data[0];
          default: ;
        endcase
      end

      pv_r <= (state_r == tsof_pkg::ST_MUL);

      if (fin_go) begin
        out_valid_r <= 1'b1;
        pi2_r       <= pi1_r;
        pi1_r       <= x_r;
        po2_r       <= po1_r;
        po1_r       <= y;
      end else if (out_m.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath; no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      tsof_pkg::ST_IDLE: begin
        x_r  <= in_s.sample;
        t_r  <= in_s.step_time_us;
        ph_r <= 1'b0;
        j_r  <= '0;
        c_r  <= '0;
      end
      tsof_pkg::ST_PREP: begin
        pt_r     <= tsof_pkg::PT_W'(t_r * tsof_pkg::TWO_PER_US);
        tt_r     <= tsof_pkg::TT_W'(t_r * t_r);
        vec_r[0] <= VW'(x_r) - (VW'(pi1_r) <<< 1) + VW'(pi2_r);
        vec_r[1] <= VW'(x_r) - VW'(pi2_r);
        vec_r[2] <= VW'(x_r) + (VW'(pi1_r) <<< 1) + VW'(pi2_r);
        vec_r[3] <= (VW'(po1_r) <<< 1) - VW'(po2_r);
        vec_r[4] <= VW'(po2_r);
        vec_r[5] <= -((VW'(po1_r) <<< 1) + VW'(po2_r));
        for (int k = 0; k < tsof_pkg::NTERM; k++) begin
          coef_r[k] <= '0;
        end
        acc_r <= '0;
      end
      tsof_pkg::ST_MUL: begin
        // Advance chunk, then term, then pass.
        if (last_c) begin
          c_r <= '0;
          if (j_r == 3'd5) begin
            j_r  <= '0;
            ph_r <= 1'b1;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end else begin
          c_r <= c_r + 2'd1;
        end
      end
      tsof_pkg::ST_DIVP1: begin
        den_r  <= NW'(coef_r[3]) + NW'(coef_r[4]) + NW'(coef_r[5]);
        nneg_r <= acc_r[AW-1];
        nabs_r <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
      end
      tsof_pkg::ST_DIVP2: begin
        inv_r  <= (den_r == '0);
        neg_r  <= nneg_r ^ den_r[NW-1];
        dabs_r <= den_r[NW-1] ? NW'(-den_r) : NW'(den_r);
      end
      tsof_pkg::ST_DIVP3: begin
        rem_r <= (nabs_r << 1) + AW'(dabs_r);
        ds_r  <= AW'(dabs_r) << (QW + 1);
        q_r   <= '0;
        cnt_r <= '0;
      end
      tsof_pkg::ST_DIV: begin
        if (ge) rem_r <= rem_r - ds_r;
        q_r   <= {q_r[QW-2:0], ge};
        if (cnt_r == '0) ovf_r <= ge;
        ds_r  <= ds_r >> 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase

    // Multiplier stage, then accumulate in the following cycle.
    prod_r <= op_a * op_b;
    pph_r  <= ph_r;
    pj_r   <= j_r;
    psh_r  <= sh;
    if (pv_r) begin
      if (!pph_r) coef_r[pj_r] <= coef_r[pj_r] + CW'(ext);
      else        acc_r        <= acc_r + ext;
    end

    if (fin_go) begin
      filt_r    <= y;
      inv_out_r <= inv_r;
    end
  end

  // Assertions.
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && inv_out_r |-> filt_r == '0)
    else $error("invalid result carries nonzero value");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == tsof_pkg::ST_FIN))
    else $error("result raised outside finish");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.valid && in_s.ready |=> state_r == tsof_pkg::ST_PREP)
    else $error("accepted word did not start prep");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clamp_en_r |-> filt_r <= $signed({1'b0, clamp_lim_r})
      && filt_r >= -$signed({1'b0, clamp_lim_r}))
    else $error("clamped result out of range");

endmodule
